[hw/rtl/plc_pkg.sv]
// ----------------------------------------------------------------------------
// plc_pkg
// shared types, constants and letter helpers of the digraph cipher
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

  localparam int NUM_LETTERS = 25;
  localparam int SIDE        = 5;

  localparam logic [4:0] IDX_V     = 5'd21;
  localparam logic [4:0] IDX_X     = 5'd22;
  localparam logic [4:0] IDX_SPACE = 5'd25;
  localparam logic [4:0] IDX_BAD   = 5'd26;
  localparam logic [4:0] IDX_LAST  = 5'(NUM_LETTERS - 1);

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_Z     = 8'h5a;
  localparam logic [7:0] ASCII_V     = 8'h56;
  localparam logic [7:0] ASCII_W     = 8'h57;
  localparam logic [7:0] ASCII_X     = 8'h58;
  localparam logic [7:0] ASCII_LA    = 8'h61;
  localparam logic [7:0] ASCII_LZ    = 8'h7a;
  localparam logic [7:0] CASE_GAP    = 8'h20;

  typedef enum logic [1:0] {
    CMD_KEY_LETTER  = 2'd0,
    CMD_KEY_END     = 2'd1,
    CMD_TEXT_LETTER = 2'd2,
    CMD_TEXT_END    = 2'd3
  } plc_cmd_t;

  typedef enum logic [1:0] {
    STATUS_PAIR = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_DONE = 2'd2
  } plc_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS,
    ST_SQ
  } plc_state_t;

  // letter index 0..24, space and bad as escape codes
  function automatic logic [4:0] classify(input logic [7:0] ch);
    logic [7:0] c;
    begin
      c = ch;
      if (ch == ASCII_SPACE) return IDX_SPACE;
      if (c >= ASCII_LA && c <= ASCII_LZ) c = c - CASE_GAP;
      if (c < ASCII_A || c > ASCII_Z) return IDX_BAD;
      if (c == ASCII_W) c = ASCII_V;
      if (c < ASCII_W) return 5'(c - ASCII_A);
      return 5'(c - ASCII_A - 8'd1);
    end
  endfunction

  function automatic logic [7:0] to_ascii(input logic [4:0] idx);
    begin
      if (idx < IDX_X) return ASCII_A + {3'b000, idx};
      return ASCII_X + {3'b000, idx - IDX_X};
    end
  endfunction

  function automatic logic [2:0] pos_row(input logic [4:0] p);
    begin
      if (p >= 5'd20) return 3'd4;
      if (p >= 5'd15) return 3'd3;
      if (p >= 5'd10) return 3'd2;
      if (p >= 5'd5)  return 3'd1;
      return 3'd0;
    end
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] r5;
    begin
      r5 = {2'b00, pos_row(p)};
      return 3'(p - r5 * 5'(SIDE));
    end
  endfunction

  function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
    begin
      return {2'b00, r} * 5'(SIDE) + {2'b00, c};
    end
  endfunction

  // one step around a row or column, forward or backward
  function automatic logic [2:0] wrap_step(input logic [2:0] x, input logic back);
    begin
      if (back) return (x == 3'd0) ? 3'(SIDE - 1) : x - 3'd1;
      return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/plc_if.sv]
// ----------------------------------------------------------------------------
// plc_if
// valid/ready channels for command input and pair output
// ----------------------------------------------------------------------------
`default_nettype none

interface plc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_in;

  modport source (output valid, output cmd, output char_in, input ready);
  modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

interface plc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] first_out;
  logic [7:0] second_out;
  logic       last;

  modport source (output valid, output status, output first_out, output second_out,
                  output last, input ready);
  modport sink   (input valid, input status, input first_out, input second_out,
                  input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/plc_ram.sv]
// ----------------------------------------------------------------------------
// plc_ram
// 25 x 5 memory, one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module plc_ram
  import plc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [4:0] waddr,
  input  wire logic [4:0] wdata,
  input  wire logic [4:0] raddr_a,
  input  wire logic [4:0] raddr_b,
  output logic      [4:0] rdata_a,
  output logic      [4:0] rdata_b
);

  logic [4:0] mem [NUM_LETTERS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[hw/rtl/plc_pair_map.sv]
// ----------------------------------------------------------------------------
// plc_pair_map
// column, row and rectangle rules on two square cells
// ----------------------------------------------------------------------------
`default_nettype none

module plc_pair_map
  import plc_pkg::*;
(
  input  wire logic       back,
  input  wire logic [4:0] p1,
  input  wire logic [4:0] p2,
  output logic      [4:0] q1,
  output logic      [4:0] q2
);

  logic [2:0] r1, c1, r2, c2;

  always_comb begin
    r1 = pos_row(p1);
    c1 = pos_col(p1);
    r2 = pos_row(p2);
    c2 = pos_col(p2);
    if (c1 == c2) begin
      q1 = cell_at(wrap_step(r1, back), c1);
      q2 = cell_at(wrap_step(r2, back), c1);
    end else if (r1 == r2) begin
      q1 = cell_at(r1, wrap_step(c1, back));
      q2 = cell_at(r1, wrap_step(c2, back));
    end else begin
      q1 = cell_at(r1, c2);
      q2 = cell_at(r2, c1);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/playfair_digraph_cipher.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// 5x5 digraph cipher: key square build and pair encipher/decipher
// ----------------------------------------------------------------------------
// channel   dir  transaction payload
// in_ch     in   cmd, char_in
// out_ch    out  status, first_out, second_out, last
// mode_we   in   mode_wdata (0 encrypt, 1 decrypt)
//
// key letters, spaces and single text letters leave the block idle
// a completed pair goes through position read, square read, output
// key end walks all 25 letter indices after the accept, one letter index per cycle
// key end on a complete square is accepted and does nothing
// rst clears control state; the square memories hold garbage until keyed
// a waiting result that is not drained this cycle holds off every command
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher
  import plc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  mode_we,
  input  wire logic  mode_wdata,
  plc_in_if.sink     in_ch,
  plc_out_if.source  out_ch
);

  plc_state_t state, state_next;

  // control registers
  logic        mode;
  logic [24:0] letter_used;
  logic [4:0]  key_count;
  logic [4:0]  pending_letter;
  logic        pending_valid;
  logic [4:0]  fill_idx;
  logic        pair_last;

  // output register
  logic        out_valid;
  plc_status_t out_status;
  logic [7:0]  out_first;
  logic [7:0]  out_second;
  logic        out_last;

  // decode
  plc_cmd_t    cmd;
  logic [4:0]  cls;
  logic        in_fire;
  logic        out_free;
  logic        key_full;

  // combinational controls
  logic        place_en;
  logic [4:0]  place_idx;
  logic        fill_start;
  logic        pair_start;
  logic        pair_last_next;
  logic [4:0]  rd_a, rd_b;
  logic        set_pending;
  logic        clear_pending;
  logic        imm_load;
  plc_status_t imm_status;
  logic        imm_last;
  logic        sq_load;

  // memory data
  logic [4:0]  pos_a, pos_b;
  logic [4:0]  q1, q2;
  logic [4:0]  sq_a, sq_b;

  assign cmd      = plc_cmd_t'(in_ch.cmd);
  assign cls      = classify(in_ch.char_in);
  assign key_full = key_count >= 5'(NUM_LETTERS);
  assign out_free = !out_valid || out_ch.ready;
  // idle and room for whatever result this command might make
  assign in_ch.ready = (state == ST_IDLE) && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // letter -> cell, read with the two letters of a pair
  plc_ram u_pos_ram (
    .clk     (clk),
    .we      (place_en),
    .waddr   (place_idx),
    .wdata   (key_count),
    .raddr_a (rd_a),
    .raddr_b (rd_b),
    .rdata_a (pos_a),
    .rdata_b (pos_b)
  );

  // cell -> letter, read at the two mapped cells
  plc_ram u_sq_ram (
    .clk     (clk),
    .we      (place_en),
    .waddr   (key_count),
    .wdata   (place_idx),
    .raddr_a (q1),
    .raddr_b (q2),
    .rdata_a (sq_a),
    .rdata_b (sq_b)
  );

  plc_pair_map u_pair_map (
    .back (mode),
    .p1   (pos_a),
    .p2   (pos_b),
    .q1   (q1),
    .q2   (q2)
  );

  always_comb begin
    state_next     = state;
    place_en       = 1'b0;
    place_idx      = cls;
    fill_start     = 1'b0;
    pair_start     = 1'b0;
    pair_last_next = 1'b0;
    rd_a           = pending_letter;
    rd_b           = IDX_X;
    set_pending    = 1'b0;
    clear_pending  = 1'b0;
    imm_load       = 1'b0;
    imm_status     = STATUS_BAD;
    imm_last       = 1'b0;
    sq_load        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_KEY_LETTER: begin
              // ignored once the square is full, spaces skipped
              if (!key_full && cls != IDX_SPACE) begin
                if (cls == IDX_BAD) begin
                  imm_load = 1'b1;
                end else if (!letter_used[cls]) begin
                  place_en = 1'b1;
                end
              end
            end
            CMD_KEY_END: begin
              if (!key_full) begin
                fill_start = 1'b1;
                state_next = ST_FILL;
              end
            end
            CMD_TEXT_LETTER: begin
              if (cls == IDX_SPACE) begin
                // skipped
              end else if (!key_full || cls == IDX_BAD) begin
                imm_load = 1'b1;
              end else if (!pending_valid) begin
                set_pending = 1'b1;
              end else begin
                pair_start = 1'b1;
                state_next = ST_POS;
                // doubled letter in encrypt mode: pair with X, keep pending
                if (!mode && cls == pending_letter && cls != IDX_X) begin
                  rd_b = IDX_X;
                end else begin
                  rd_b          = cls;
                  clear_pending = 1'b1;
                end
              end
            end
            CMD_TEXT_END: begin
              imm_last = 1'b1;
              if (!key_full) begin
                imm_load = 1'b1;
              end else if (pending_valid) begin
                // odd letter padded with X
                pair_start     = 1'b1;
                pair_last_next = 1'b1;
                clear_pending  = 1'b1;
                state_next     = ST_POS;
              end else begin
                imm_load   = 1'b1;
                imm_status = STATUS_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        // append the unused letters in alphabetical order
        place_idx = fill_idx;
        place_en  = !letter_used[fill_idx];
        if (fill_idx == IDX_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_POS: begin
        // positions are out of the ram, cells go to the square ram
        state_next = ST_SQ;
      end
      ST_SQ: begin
        sq_load    = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= 1'b0;
      letter_used    <= '0;
      key_count      <= '0;
      pending_letter <= '0;
      pending_valid  <= 1'b0;
      fill_idx       <= '0;
      pair_last      <= 1'b0;
    end else begin
      if (mode_we) begin
        mode <= mode_wdata;
      end
      if (place_en) begin
        letter_used[place_idx] <= 1'b1;
        key_count              <= key_count + 5'd1;
      end
      if (fill_start) begin
        fill_idx <= '0;
      end else if (state == ST_FILL) begin
        fill_idx <= fill_idx + 5'd1;
      end
      if (set_pending) begin
        pending_letter <= cls;
        pending_valid  <= 1'b1;
      end else if (clear_pending) begin
        pending_letter <= '0;
        pending_valid  <= 1'b0;
      end
      if (pair_start) begin
        pair_last <= pair_last_next;
      end
    end
  end

  // output register, loaded only when free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (imm_load || sq_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (imm_load) begin
      out_status <= imm_status;
      out_first  <= '0;
      out_second <= '0;
      out_last   <= imm_last;
    end else if (sq_load) begin
      out_status <= STATUS_PAIR;
      out_first  <= to_ascii(sq_a);
      out_second <= to_ascii(sq_b);
      out_last   <= pair_last;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_status;
  assign out_ch.first_out  = out_first;
  assign out_ch.second_out = out_second;
  assign out_ch.last       = out_last;

endmodule

`default_nettype wire

[dv/playfair_digraph_cipher_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_test
// self-checking bench for the digraph cipher: one key square is built after
// reset, then text is run in both modes. A directed table goes first, then
// random text, with random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------

module playfair_digraph_cipher_test
  import plc_pkg::*;
();

  // one expected output transaction
  typedef struct packed {
    plc_status_t status;
    logic [7:0]  first;
    logic [7:0]  second;
    logic        last;
  } pair_result_t;

  // one row of stimulus; typed rows carry their expectation inline
  typedef struct packed {
    plc_cmd_t    cmd;
    logic [7:0]  ch;
    logic        typed;
    logic        has_pair;
    plc_status_t status;
    logic        last;
  } stim_row_t;

  localparam int N_DIRECTED   = 27;
  localparam int DRAIN_CYCLES = 40;   // key end walks 25 letters, plus slack
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 290;
  localparam int HOLD_AT      = 300;  // output count at which the long stall starts
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst;
  logic mode_we;
  logic mode_wdata;

  plc_in_if  in_ch ();
  plc_out_if out_ch ();

  playfair_digraph_cipher u_dut (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // cipher state as the bench sees it
  // ---------------------------------------------------------------------------
  logic [4:0]  square_cell [NUM_LETTERS];  // letter index held by each cell
  logic [4:0]  cell_of     [NUM_LETTERS];  // cell holding each letter index
  logic [24:0] placed;
  int          filled;
  logic [4:0]  open_letter;
  bit          open_valid;
  bit          mode_shadow;

  pair_result_t expected_pairs[$];
  int           mismatch_count;
  int           sent_count;
  int           rx_count;

  // ascii to letter index; IDX_SPACE and IDX_BAD for the two escapes
  function automatic logic [4:0] letter_code(input logic [7:0] ch);
    logic [7:0] up;
    begin
      if (ch == ASCII_SPACE) return IDX_SPACE;
      up = (ch >= ASCII_LA && ch <= ASCII_LZ) ? ch - CASE_GAP : ch;
      if (up < ASCII_A || up > ASCII_Z) return IDX_BAD;
      if (up == ASCII_W) return IDX_V;   // w folds onto v
      return (up > ASCII_W) ? 5'(up - ASCII_A - 8'd1) : 5'(up - ASCII_A);
    end
  endfunction

  // letter index back to ascii, skipping w
  function automatic logic [7:0] letter_ascii(input logic [4:0] idx);
    begin
      return ASCII_A + {3'b000, idx} + ((idx >= IDX_X) ? 8'd1 : 8'd0);
    end
  endfunction

  function automatic void place_letter(input logic [4:0] idx);
    begin
      if (filled >= NUM_LETTERS) return;
      square_cell[filled] = idx;
      cell_of[idx]        = 5'(filled);
      placed[idx]         = 1'b1;
      filled++;
    end
  endfunction

  // column rule, row rule or rectangle rule; decrypt steps back by one
  function automatic pair_result_t cipher_letters(input logic [4:0] a, input logic [4:0] b,
                                                  input logic last);
    int r1, c1, r2, c2, step, q1, q2;
    begin
      r1   = cell_of[a] / SIDE;
      c1   = cell_of[a] % SIDE;
      r2   = cell_of[b] / SIDE;
      c2   = cell_of[b] % SIDE;
      step = mode_shadow ? SIDE - 1 : 1;
      if (c1 == c2) begin
        q1 = ((r1 + step) % SIDE) * SIDE + c1;
        q2 = ((r2 + step) % SIDE) * SIDE + c1;
      end else if (r1 == r2) begin
        q1 = r1 * SIDE + (c1 + step) % SIDE;
        q2 = r1 * SIDE + (c2 + step) % SIDE;
      end else begin
        q1 = r1 * SIDE + c2;
        q2 = r2 * SIDE + c1;
      end
      return '{STATUS_PAIR, letter_ascii(square_cell[q1]), letter_ascii(square_cell[q2]), last};
    end
  endfunction

  // advance the bench's cipher state by one accepted command
  function automatic void predict_pair(input plc_cmd_t c, input logic [7:0] ch,
                                       output bit got, output pair_result_t res);
    logic [4:0] code;
    begin
      code = letter_code(ch);
      got  = 1'b0;
      res  = '{STATUS_BAD, 8'h00, 8'h00, 1'b0};
      case (c)
        CMD_KEY_LETTER: begin
          // a complete square ignores everything, bad characters too
          if (filled >= NUM_LETTERS || code == IDX_SPACE) return;
          if (code == IDX_BAD) begin
            got = 1'b1;
            return;
          end
          if (!placed[code]) place_letter(code);
        end
        CMD_KEY_END: begin
          for (int i = 0; i < NUM_LETTERS; i++)
            if (!placed[i]) place_letter(5'(i));
        end
        CMD_TEXT_LETTER: begin
          if (code == IDX_SPACE) return;
          if (filled < NUM_LETTERS || code == IDX_BAD) begin
            got = 1'b1;
            return;
          end
          if (!open_valid) begin
            open_letter = code;
            open_valid  = 1'b1;
            return;
          end
          got = 1'b1;
          if (!mode_shadow && code == open_letter && code != IDX_X) begin
            // doubled letter: x goes in, the letter stays open
            res = cipher_letters(open_letter, IDX_X, 1'b0);
          end else begin
            res         = cipher_letters(open_letter, code, 1'b0);
            open_valid  = 1'b0;
            open_letter = '0;
          end
        end
        default: begin
          got = 1'b1;
          if (filled < NUM_LETTERS) begin
            res.last = 1'b1;
          end else if (open_valid) begin
            // odd letter at the end is padded with x in either mode
            res         = cipher_letters(open_letter, IDX_X, 1'b1);
            open_valid  = 1'b0;
            open_letter = '0;
          end else begin
            res = '{STATUS_DONE, 8'h00, 8'h00, 1'b1};
          end
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side: offer one row, hold it until the transaction goes through
  // ---------------------------------------------------------------------------
  task automatic offer_row(input stim_row_t row);
    bit           got;
    pair_result_t res;
    begin
      // random gaps, except for a calm stretch in the middle of the run
      while (!(sent_count >= 900 && sent_count < 1300) && $urandom_range(99) < 23) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      in_ch.valid   <= 1'b1;
      in_ch.cmd     <= row.cmd;
      in_ch.char_in <= row.ch;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      sent_count++;
      predict_pair(row.cmd, row.ch, got, res);
      if (row.typed) begin
        got = row.has_pair;
        res = '{row.status, 8'h00, 8'h00, row.last};
      end
      if (got) expected_pairs.push_back(res);
    end
  endtask

  // mode changes only with the block drained
  task automatic write_mode(input bit m);
    begin
      in_ch.valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      mode_we    <= 1'b1;
      mode_wdata <= m;
      @(posedge clk);
      mode_we     <= 1'b0;
      mode_shadow  = m;
    end
  endtask

  // mostly well-formed text with doubled letters, plus spaces, junk and key noise
  task automatic run_text_phase(input int n_items);
    int         done;
    int         roll;
    logic [7:0] prev_letter;
    stim_row_t  row;
    begin
      done        = 0;
      prev_letter = "E";
      while (done < n_items) begin
        roll      = $urandom_range(99);
        row       = '0;
        row.cmd   = CMD_TEXT_LETTER;
        row.ch    = 8'($urandom_range(255));
        if (roll < 70) begin
          row.ch = ($urandom_range(99) < 20) ? prev_letter : ASCII_A + 8'($urandom_range(25));
          prev_letter = row.ch;
          if ($urandom_range(1)) row.ch = row.ch | CASE_GAP;
        end else if (roll < 78) begin
          row.cmd = CMD_TEXT_END;
        end else if (roll < 85) begin
          row.ch = ASCII_SPACE;
        end else if (roll >= 93) begin
          // key commands after the square is complete change nothing
          row.cmd = $urandom_range(1) ? CMD_KEY_END : CMD_KEY_LETTER;
        end
        // the remaining rolls keep the random byte, mostly junk
        offer_row(row);
        done++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table: errors before the key, key build with repeats and
  // case folding, ignored key commands, then doubled letters and padding
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_TEXT_LETTER, "A",   1'b1, 1'b1, STATUS_BAD,  1'b0},  // text with no square yet
    '{CMD_TEXT_END,    8'h00, 1'b1, 1'b1, STATUS_BAD,  1'b1},
    '{CMD_TEXT_LETTER, " ",   1'b1, 1'b0, STATUS_PAIR, 1'b0},  // space skipped
    '{CMD_KEY_LETTER,  " ",   1'b1, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_KEY_LETTER,  "1",   1'b1, 1'b1, STATUS_BAD,  1'b0},
    '{CMD_KEY_LETTER,  8'hff, 1'b1, 1'b1, STATUS_BAD,  1'b0},
    '{CMD_KEY_LETTER,  8'h00, 1'b1, 1'b1, STATUS_BAD,  1'b0},
    '{CMD_KEY_LETTER,  "p",   1'b1, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_KEY_LETTER,  "L",   1'b1, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_KEY_LETTER,  "a",   1'b1, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_KEY_LETTER,  "Y",   1'b1, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_KEY_LETTER,  "f",   1'b1, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_KEY_LETTER,  "A",   1'b1, 1'b0, STATUS_PAIR, 1'b0},  // repeat, dropped
    '{CMD_KEY_LETTER,  "w",   1'b1, 1'b0, STATUS_PAIR, 1'b0},  // lands as v
    '{CMD_KEY_LETTER,  "V",   1'b1, 1'b0, STATUS_PAIR, 1'b0},  // already placed through w
    '{CMD_KEY_LETTER,  "z",   1'b1, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_KEY_END,     8'h00, 1'b1, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_KEY_LETTER,  "Q",   1'b1, 1'b0, STATUS_PAIR, 1'b0},  // square complete
    '{CMD_KEY_LETTER,  "#",   1'b1, 1'b0, STATUS_PAIR, 1'b0},  // even junk is ignored now
    '{CMD_KEY_END,     8'hff, 1'b1, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_TEXT_END,    8'h00, 1'b1, 1'b1, STATUS_DONE, 1'b1},  // nothing open
    '{CMD_TEXT_LETTER, "~",   1'b1, 1'b1, STATUS_BAD,  1'b0},
    '{CMD_TEXT_LETTER, "h",   1'b0, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_TEXT_LETTER, "H",   1'b0, 1'b0, STATUS_PAIR, 1'b0},  // doubled, x inserted
    '{CMD_TEXT_LETTER, "X",   1'b0, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_TEXT_LETTER, "Z",   1'b0, 1'b0, STATUS_PAIR, 1'b0},
    '{CMD_TEXT_END,    8'h00, 1'b0, 1'b0, STATUS_PAIR, 1'b0}   // last letter padded
  };

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    mode_we        = 1'b0;
    mode_wdata     = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_KEY_LETTER;
    in_ch.char_in  = 8'h00;
    placed         = '0;
    filled         = 0;
    open_letter    = '0;
    open_valid     = 1'b0;
    mode_shadow    = 1'b0;
    mismatch_count = 0;
    sent_count     = 0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      square_cell[i] = '0;
      cell_of[i]     = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    foreach (directed_rows[i]) offer_row(directed_rows[i]);

    // alternate decrypt and encrypt; an open letter carries across a change
    for (int p = 0; p < N_PHASES; p++) begin
      write_mode(p % 2 == 0);
      run_text_phase(PHASE_ITEMS);
    end
    in_ch.valid <= 1'b0;

    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_pairs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // output side: check each transaction, drive ready with random stalls,
  // one long hold-off, and a calm stretch with ready always high
  // ---------------------------------------------------------------------------
  initial begin
    int           hold_left;
    pair_result_t want;
    out_ch.ready = 1'b0;
    rx_count     = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d %h %h last %0d",
                   $time, out_ch.status, out_ch.first_out, out_ch.second_out, out_ch.last);
          mismatch_count++;
        end else begin
          want = expected_pairs.pop_front();
          if (out_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_ch.status);
            mismatch_count++;
          end
          if (out_ch.first_out !== want.first) begin
            $display("%0t: first_out mismatch, expected %h, actual %h",
                     $time, want.first, out_ch.first_out);
            mismatch_count++;
          end
          if (out_ch.second_out !== want.second) begin
            $display("%0t: second_out mismatch, expected %h, actual %h",
                     $time, want.second, out_ch.second_out);
            mismatch_count++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last mismatch, expected %0d, actual %0d",
                     $time, want.last, out_ch.last);
            mismatch_count++;
          end
        end
        rx_count++;
        if (rx_count == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // the sender keeps offering, so the block backs up and stalls its input
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (rx_count >= 120 && rx_count < 260) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 23);
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
hw/rtl/plc_pkg.sv
hw/rtl/plc_if.sv
hw/rtl/plc_ram.sv
hw/rtl/plc_pair_map.sv
hw/rtl/playfair_digraph_cipher.sv
dv/playfair_digraph_cipher_test.sv
